// ===== design/padc_pkg.sv =====
`timescale 1ns / 1ps
package padc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CODE_W     = 10;
  localparam int DIGITS_W   = 20;
  localparam int PACK_W     = 60;
  localparam int FIELD_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int GAIN_BASE  = 256;
  localparam int GAIN_SHIFT = 8;
  localparam int OFF_LSB    = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET = 2'd0,
    REG_GAIN   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIG_NEG  = 2'd0,
    DIG_ZERO = 2'd1,
    DIG_POS  = 2'd2
  } digit_t;

endpackage

// ===== design/pipelined_adc_stage_chain_model.sv =====
`timescale 1ns / 1ps
// 1.5-bit-per-stage pipelined ADC chain with redundant digital correction.
// Input: a sample transaction is taken on a rising edge with start high and
//   busy low. busy is high only for the first cycle after reset.
// Config: cfg_we / cfg_index / cfg_wdata write the offset pack (index 0) or
//   the gain pack (index 1); other indexes are dropped. Write only while idle.
// Output: out_valid strobes for one cycle with out_code, out_stage_digits and
//   out_saturated. The receiver cannot stall, so nothing ever backs up.
// Pipeline: one input register, two register steps per stage (compare, then
//   the gain multiply with floor and clip) and one output register.
// Throughput: one transaction per cycle, every cycle once busy has dropped
//   after reset; the per-stage gain multiplier is the deepest path.
// Reset: synchronous, active low; clears all valid bits, the output strobe
//   and both config packs. Transactions in flight are dropped.
module pipelined_adc_stage_chain_model #(
  parameter int NUM_STAGES = 10,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [padc_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                  out_valid,
  output logic        [padc_pkg::CODE_W-1:0]    out_code,
  output logic        [padc_pkg::DIGITS_W-1:0]  out_stage_digits,
  output logic                                  out_saturated,
  input  logic                                  cfg_we,
  input  logic        [padc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [padc_pkg::PACK_W-1:0]    cfg_wdata
);
  import padc_pkg::*;

  localparam int XW  = (FRAC_BITS + 2 > SAMPLE_W) ? FRAC_BITS + 2 : SAMPLE_W;
  localparam int VW  = XW + 2;
  localparam int GW  = 10;
  localparam int PW  = VW + GW;
  localparam int AW  = NUM_STAGES + 1;
  localparam int DW  = 2 * NUM_STAGES;
  localparam int LAT = 2 * NUM_STAGES + 2;

  localparam logic signed [XW:0]    QTR_P = (XW+1)'(2**(FRAC_BITS-2));
  localparam logic signed [XW:0]    QTR_N = -QTR_P;
  localparam logic signed [VW-1:0]  ONE_V = VW'(2**FRAC_BITS);
  localparam logic signed [PW-1:0]  HI_P  = PW'(2 * 2**FRAC_BITS - 1);
  localparam logic signed [PW-1:0]  LO_P  = -PW'(2 * 2**FRAC_BITS);
  localparam logic signed [XW-1:0]  HI_X  = XW'(HI_P);
  localparam logic signed [XW-1:0]  LO_X  = XW'(LO_P);
  localparam logic signed [AW:0]    CODE_BIAS = (AW+1)'(2**NUM_STAGES - 1);

  logic [PACK_W-1:0] cfg_offset_r;
  logic [PACK_W-1:0] cfg_gain_r;
  logic              busy_r;
  logic              in_acc;

  // residue side: entry 0 is the input register, entry i+1 leaves stage i
  logic signed [XW-1:0] x_r   [0:NUM_STAGES];
  logic                 vx_r  [0:NUM_STAGES];
  logic        [DW-1:0] dg_r  [0:NUM_STAGES];
  logic signed [AW-1:0] acc_r [0:NUM_STAGES];
  logic                 sat_r [0:NUM_STAGES];

  // compare side of each stage
  logic signed [VW-1:0] v_r    [0:NUM_STAGES-1];
  logic                 va_r   [0:NUM_STAGES-1];
  logic        [DW-1:0] dga_r  [0:NUM_STAGES-1];
  logic signed [AW-1:0] acca_r [0:NUM_STAGES-1];
  logic                 sata_r [0:NUM_STAGES-1];

  logic                 out_valid_r;
  logic [CODE_W-1:0]    out_code_r;
  logic [DIGITS_W-1:0]  out_digits_r;
  logic                 out_sat_r;
  logic signed [AW:0]   csum;

  assign in_acc = start & ~busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      cfg_offset_r <= '0;
      cfg_gain_r   <= '0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET: cfg_offset_r <= cfg_wdata;
          REG_GAIN:   cfg_gain_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r[0] <= 1'b0;
    end else begin
      vx_r[0] <= in_acc;
    end
    x_r[0]   <= XW'(in_sample);
    dg_r[0]  <= '0;
    acc_r[0] <= '0;
    sat_r[0] <= 1'b0;
  end

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    logic signed [FIELD_W-1:0] off6;
    logic signed [FIELD_W-1:0] g6;
    logic signed [XW-1:0]      off;
    logic signed [XW:0]        s;
    digit_t                    d;
    logic signed [1:0]         dval;
    logic signed [VW-1:0]      dterm;
    logic signed [VW-1:0]      v;
    logic signed [GW-1:0]      gm;
    logic signed [PW-1:0]      p;
    logic signed [PW-1:0]      r;
    logic signed [XW-1:0]      rc;
    logic                      clip;

    assign off6 = cfg_offset_r[FIELD_W*i +: FIELD_W];
    assign off  = XW'(off6) <<< (FRAC_BITS - OFF_LSB);
    assign s    = (XW+1)'(x_r[i]) + (XW+1)'(off);

    always_comb begin
      if (s < QTR_N) begin
        d     = DIG_NEG;
        dval  = -2'sd1;
        dterm = -ONE_V;
      end else if (s < QTR_P) begin
        d     = DIG_ZERO;
        dval  = 2'sd0;
        dterm = '0;
      end else begin
        d     = DIG_POS;
        dval  = 2'sd1;
        dterm = ONE_V;
      end
    end

    assign v = $signed({x_r[i][XW-1], x_r[i], 1'b0}) - dterm;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[i] <= 1'b0;
      end else begin
        va_r[i] <= vx_r[i];
      end
      v_r[i]    <= v;
      dga_r[i]  <= {dg_r[i][DW-3:0], d};
      acca_r[i] <= (acc_r[i] <<< 1) + AW'(dval);
      sata_r[i] <= sat_r[i];
    end

    assign g6 = cfg_gain_r[FIELD_W*i +: FIELD_W];
    assign gm = GW'(GAIN_BASE) + GW'(g6);
    assign p  = v_r[i] * gm;
    assign r  = p >>> GAIN_SHIFT;

    always_comb begin
      if (r > HI_P) begin
        rc   = HI_X;
        clip = 1'b1;
      end else if (r < LO_P) begin
        rc   = LO_X;
        clip = 1'b1;
      end else begin
        rc   = XW'(r);
        clip = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vx_r[i+1] <= 1'b0;
      end else begin
        vx_r[i+1] <= va_r[i];
      end
      x_r[i+1]   <= rc;
      dg_r[i+1]  <= dga_r[i];
      acc_r[i+1] <= acca_r[i];
      sat_r[i+1] <= sata_r[i] | clip;
    end
  end

  assign csum = (AW+1)'(acc_r[NUM_STAGES]) + CODE_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vx_r[NUM_STAGES];
    end
    out_code_r   <= CODE_W'(csum[AW-1:1]);
    out_digits_r <= DIGITS_W'(dg_r[NUM_STAGES]);
    out_sat_r    <= sat_r[NUM_STAGES];
  end

  assign out_valid        = out_valid_r;
  assign out_code         = out_code_r;
  assign out_stage_digits = out_digits_r;
  assign out_saturated    = out_sat_r;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without matching accepted transaction");

  a_code_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_code == '0) |->
      (out_stage_digits[DW-1:DW-2] == DIG_NEG))
    else $error("zero code without negative first digit");

  a_code_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_code == CODE_W'(2**NUM_STAGES - 1)) |->
      (out_stage_digits[DW-1:DW-2] == DIG_POS))
    else $error("full-scale code without positive first digit");

  for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_chk
    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
      vx_r[k] |-> (x_r[k] >= LO_X && x_r[k] <= HI_X))
      else $error("stage residue outside clip range");
  end
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import padc_pkg::*;

  localparam int NSTG = 10;
  localparam int FRAC = 14;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint QUARTER = longint'(1) << (FRAC - 2);
  localparam longint OFF_UNIT = longint'(1) << (FRAC - OFF_LSB);
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * NSTG + 12;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [DIGITS_W-1:0] digits;
    logic                sat;
  } conv_t;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic signed [SAMPLE_W-1:0]  in_sample;
  logic                        out_valid;
  logic [CODE_W-1:0]           out_code;
  logic [DIGITS_W-1:0]         out_stage_digits;
  logic                        out_saturated;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [PACK_W-1:0]           cfg_wdata;

  logic [PACK_W-1:0] offset_q = '0;
  logic [PACK_W-1:0] gain_q = '0;
  conv_t             conv_q[$];
  int                errors = 0;
  int                stall_cycles = 0;
  bit                gaps_on = 1;

  pipelined_adc_stage_chain_model dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_code         (out_code),
    .out_stage_digits (out_stage_digits),
    .out_saturated    (out_saturated),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic conv_t convert_sample(input logic signed [SAMPLE_W-1:0] smp,
                                           input logic [PACK_W-1:0] offs,
                                           input logic [PACK_W-1:0] gains);
    conv_t res;
    longint x, s, r, d, g, off, total;
    logic signed [FIELD_W-1:0] f;
    int i;
    res = '0;
    x = smp;
    total = (longint'(1) << NSTG) - 1;
    for (i = 0; i < NSTG; i++) begin
      f = offs[FIELD_W*i +: FIELD_W];
      off = longint'(f) * OFF_UNIT;
      f = gains[FIELD_W*i +: FIELD_W];
      g = longint'(f);
      s = x + off;
      if (s < -QUARTER) begin
        d = -1;
        res.digits[2*(NSTG-1-i) +: 2] = DIG_NEG;
      end else if (s < QUARTER) begin
        d = 0;
        res.digits[2*(NSTG-1-i) +: 2] = DIG_ZERO;
      end else begin
        d = 1;
        res.digits[2*(NSTG-1-i) +: 2] = DIG_POS;
      end
      total += d * (longint'(1) << (NSTG - 1 - i));
      // arithmetic shift of a signed product floors toward minus infinity
      r = ((2 * x - d * ONE) * (GAIN_BASE + g)) >>> GAIN_SHIFT;
      if (r > 2 * ONE - 1) begin
        r = 2 * ONE - 1;
        res.sat = 1'b1;
      end else if (r < -2 * ONE) begin
        r = -2 * ONE;
        res.sat = 1'b1;
      end
      x = r;
    end
    res.code = CODE_W'(total >> 1);
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [FIELD_W-1:0] f;
    longint off, v;
    f = offset_q[FIELD_W-1:0];
    off = longint'(f) * OFF_UNIT;
    case ($urandom_range(0, 3))
      0: v = longint'($urandom);
      1: v = ($urandom_range(0, 1) ? QUARTER : -QUARTER) - off
             + longint'(int'($urandom_range(0, 8))) - 4;
      2: v = longint'(int'($urandom_range(0, 2 * QUARTER))) - QUARTER;
      default: v = $urandom_range(0, 1) ? 32767 - longint'(int'($urandom_range(0, 63)))
                                        : -32768 + longint'(int'($urandom_range(0, 63)));
    endcase
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [PACK_W-1:0] rand_pack();
    return PACK_W'({$urandom, $urandom});
  endfunction

  task automatic report(input string what, input conv_t want, input conv_t got);
    errors++;
    if (errors <= 10)
      $display("%s: exp code=%0d digits=%h sat=%0d, got code=%0d digits=%h sat=%0d",
               what, want.code, want.digits, want.sat, got.code, got.digits, got.sat);
  endtask

  always @(posedge clk) begin : monitor
    conv_t got, want;
    if (rst_n && start && !busy)
      conv_q.push_back(convert_sample(in_sample, offset_q, gain_q));
    if (rst_n && out_valid) begin
      got.code = out_code;
      got.digits = out_stage_digits;
      got.sat = out_saturated;
      if (conv_q.size() == 0) begin
        report("unexpected transaction", '0, got);
      end else begin
        want = conv_q.pop_front();
        if (got !== want)
          report("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // callers enter and leave just after a falling edge
  task automatic send(input logic signed [SAMPLE_W-1:0] v);
    start = 1'b1;
    in_sample = v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 16) begin
      start = 1'b0;
      in_sample = SAMPLE_W'($urandom);
      @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (conv_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PACK_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    if (idx == REG_OFFSET)
      offset_q = data;
    else if (idx == REG_GAIN)
      gain_q = data;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = rand_pack();
  endtask

  task automatic test_sample_extremes();
    send(-16'sd32768);
    send(16'sd32767);
    send(16'sd0);
    send(-16'sd1);
    send(SAMPLE_W'(QUARTER - 1));
    send(SAMPLE_W'(QUARTER));
    send(SAMPLE_W'(-QUARTER));
    send(SAMPLE_W'(-QUARTER - 1));
    send(SAMPLE_W'(ONE));
    send(SAMPLE_W'(-ONE));
  endtask

  task automatic test_config_extremes();
    logic [PACK_W-1:0] offs[3];
    logic [PACK_W-1:0] gains[3];
    logic signed [FIELD_W-1:0] f;
    int k;
    offs[0] = {10{6'h20}};
    gains[0] = {10{6'h1f}};
    offs[1] = {10{6'h1f}};
    gains[1] = {10{6'h20}};
    offs[2] = {5{12'h81f}};
    gains[2] = {5{12'h7e0}};
    for (k = 0; k < 3; k++) begin
      wait_idle();
      write_reg(REG_OFFSET, offs[k]);
      write_reg(REG_GAIN, gains[k]);
      f = offs[k][FIELD_W-1:0];
      send(SAMPLE_W'(QUARTER - longint'(f) * OFF_UNIT));
      send(SAMPLE_W'(-QUARTER - longint'(f) * OFF_UNIT));
      send(k[0] ? -16'sd32768 : 16'sd32767);
    end
  endtask

  task automatic test_spare_index();
    wait_idle();
    write_reg(REG_SPARE_2, rand_pack());
    write_reg(REG_SPARE_3, rand_pack());
    send(rand_sample());
    send(rand_sample());
  endtask

  task automatic test_random_stream();
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(REG_OFFSET, '0);
          write_reg(REG_GAIN, '0);
        end
        1: begin
          write_reg(REG_OFFSET, {10{6'h1f}});
          write_reg(REG_GAIN, {10{6'h1f}});
        end
        2: begin
          write_reg(REG_OFFSET, {10{6'h20}});
          write_reg(REG_GAIN, {10{6'h20}});
        end
        default: begin
          write_reg(REG_OFFSET, rand_pack());
          write_reg(REG_GAIN, rand_pack());
        end
      endcase
      gaps_on = (phase != 3);
      repeat (210) send(rand_sample());
    end
    gaps_on = 1;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_sample = '0;
    cfg_we = 1'b0;
    cfg_index = REG_OFFSET;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_sample_extremes();
    test_config_extremes();
    test_spare_index();
    test_random_stream();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && conv_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/padc_pkg.sv
design/pipelined_adc_stage_chain_model.sv
verif/tb_top.sv
